// ===== src/lzh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzh_pkg
// Shared types and codes of the lz/huffman decompressor.
// ----------------------------------------------------------------------------
package lzh_pkg;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_REQ   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_OVERRUN  = 3'd1;
  localparam logic [2:0] ERR_LENGTH   = 3'd2;
  localparam logic [2:0] ERR_DISTANCE = 3'd3;
  localparam logic [2:0] ERR_TREE     = 3'd4;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [1:0] PH_FAIL = 2'd3;

  localparam logic CFG_SYM_BITS  = 1'b0;
  localparam logic CFG_DIST_BITS = 1'b1;

  localparam logic [3:0] SYM_BITS_RST  = 4'd9;
  localparam logic [3:0] DIST_BITS_RST = 4'd11;
  localparam logic [4:0] SYM_BITS_MIN  = 5'd9;
  localparam logic [4:0] DIST_BITS_MIN = 5'd1;

  localparam int SIZE_WORD     = 1;
  localparam int DIST_OFS_WORD = 2;
  localparam int HDR_WORDS     = 3;
  localparam int SYM_START     = 12;
  localparam int LEN_BASE      = 256;
  localparam int LEN_ADD       = 3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] data_word;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] error;
  } out_word_t;

  typedef struct packed {
    logic       index;
    logic [3:0] value;
  } cfg_word_t;

endpackage

// ===== src/lzh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzh channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface lzh_in_if;
  import lzh_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lzh_out_if;
  import lzh_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lzh_cfg_if;
  import lzh_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/lz_huffman_tree_decompressor_top.sv =====
`timescale 1ns / 1ps
// Load/clear stay in S_WAIT; one word in flight, next accepted when the result is taken.
// A literal walks node memory bit by bit, refilling the 32-bit stream word when used up.
// A copied byte reads the window memory; a match start adds the distance walk.
// The first request builds both trees, reading tree bits and pushing/popping nodes on a stack.
// Reset is asynchronous; it clears control state only, memories keep contents and need no sweep.
// ----------------------------------------------------------------------------
// lz_huffman_tree_decompressor_top
// LZ77 decompressor with huffman-tree coded literal/length and distance streams.
// ----------------------------------------------------------------------------
module lz_huffman_tree_decompressor_top #(
  parameter int COMPRESSED_WORDS  = 16384,
  parameter int MAX_SYMBOL_BITS   = 12,
  parameter int MAX_DISTANCE_BITS = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lzh_cfg_if.sink   cfg_i,
  lzh_in_if.sink    in_i,
  lzh_out_if.source out_o
);
  import lzh_pkg::*;

  localparam int SB = MAX_SYMBOL_BITS;
  localparam int DB = MAX_DISTANCE_BITS;
  localparam int MaxBits = (SB > DB) ? SB : DB;
  localparam int NW = MaxBits + 1;
  localparam int AW = (COMPRESSED_WORDS > 1) ? $clog2(COMPRESSED_WORDS) : 1;
  localparam int CW = $clog2(COMPRESSED_WORDS + 1);
  localparam int PW = 33;

  localparam logic [4:0] S_WAIT   = 5'd0;
  localparam logic [4:0] S_H2     = 5'd1;
  localparam logic [4:0] S_H3     = 5'd2;
  localparam logic [4:0] S_H4     = 5'd3;
  localparam logic [4:0] S_F0     = 5'd4;
  localparam logic [4:0] S_F1     = 5'd5;
  localparam logic [4:0] S_F2     = 5'd6;
  localparam logic [4:0] S_BBIT   = 5'd7;
  localparam logic [4:0] S_BACT   = 5'd8;
  localparam logic [4:0] S_BPUSHL = 5'd9;
  localparam logic [4:0] S_BLEAF  = 5'd10;
  localparam logic [4:0] S_BPOP   = 5'd11;
  localparam logic [4:0] S_BPOPD  = 5'd12;
  localparam logic [4:0] S_DEC    = 5'd13;
  localparam logic [4:0] S_WALK   = 5'd14;
  localparam logic [4:0] S_WRD    = 5'd15;
  localparam logic [4:0] S_CPY    = 5'd16;

  logic [4:0]  st_q, st_d, ret_q, ret_d;
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  err_q, err_d;
  logic [3:0]  sym_bits_q, dist_bits_q;
  logic [4:0]  jsb_q, jsb_d, jdb_q, jdb_d;
  logic [CW-1:0] wcnt_q, wcnt_d;
  logic [31:0] rword_q [2];
  logic [31:0] rword_d [2];
  logic [4:0]  rused_q [2];
  logic [4:0]  rused_d [2];
  logic [PW-1:0] rpos_q [2];
  logic [PW-1:0] rpos_d [2];
  logic        rsel_q, rsel_d, tsel_q, tsel_d, bit_q, bit_d;
  logic [NW-1:0] cur_q, cur_d, next_q, next_d, sroot_q, sroot_d, droot_q, droot_d;
  logic [NW-1:0] len_q, len_d, sp_q, sp_d;
  logic [4:0]  bcnt_q, bcnt_d;
  logic [23:0] size_q, size_d, rem_q, rem_d, prod_q, prod_d, cleft_q, cleft_d;
  logic [DB-1:0] cdist_q, cdist_d;
  logic [AW-1:0] fadr_q, fadr_d;
  logic [31:0] w0_q, w0_d;
  logic        ovalid_q, ovalid_d;
  out_word_t   ores_q, ores_d;

  // compressed word memory
  logic [31:0]   cmem [COMPRESSED_WORDS];
  logic          cm_we, cm_re;
  logic [AW-1:0] cm_waddr, cm_raddr;
  logic [31:0]   cm_rdata_q;

  // tree node memories
  logic [SB:0]   sym_l [2**SB];
  logic [SB:0]   sym_r [2**SB];
  logic [DB:0]   dst_l [2**DB];
  logic [DB:0]   dst_r [2**DB];
  logic          node_we_l, node_we_r, node_re;
  logic [MaxBits-1:0] node_addr;
  logic [SB:0]   sl_rdata_q, sr_rdata_q;
  logic [DB:0]   dl_rdata_q, dr_rdata_q;

  // tree build stack, tag bit on top
  logic [NW:0]   stk [2**NW];
  logic          stk_we, stk_re;
  logic [NW-1:0] stk_waddr, stk_raddr;
  logic [NW:0]   stk_wdata, stk_rdata_q;

  // output window
  logic [7:0]    win [2**DB];
  logic          win_we, win_re;
  logic [DB-1:0] win_waddr, win_raddr;
  logic [7:0]    win_wdata, win_rdata_q;

  logic          in_acc, rbit, rlast, consume, do_emit, do_fail, bdone;
  logic [4:0]    nxt;
  logic [7:0]    emit_byte;
  logic [2:0]    fail_code;
  logic [NW-1:0] lim, lim2, ndiff, nl, nr;
  logic [PW-1:0] rp;
  logic [63:0]   fsh;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (st_q == S_WAIT) && !ovalid_q;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = ovalid_q;
  assign out_o.data  = ores_q;

  assign rbit  = rword_q[rsel_q][31];
  assign rlast = rused_q[rsel_q] == 5'd31;
  assign rp    = rpos_q[rsel_q];
  assign lim   = NW'(1) << (tsel_q ? jdb_q : jsb_q);
  assign lim2  = NW'((lim - NW'(1)) << 1);
  assign ndiff = ((st_q == S_BPOPD) ? stk_rdata_q[NW-1:0] : cur_q) - lim;
  assign nl    = tsel_q ? NW'(dl_rdata_q) : NW'(sl_rdata_q);
  assign nr    = tsel_q ? NW'(dr_rdata_q) : NW'(sr_rdata_q);
  assign fsh   = {w0_q, cm_rdata_q} << {rp[1:0], 3'b000};

  always_comb begin
    st_d = st_q;  ret_d = ret_q;  phase_d = phase_q;  err_d = err_q;
    jsb_d = jsb_q;  jdb_d = jdb_q;  wcnt_d = wcnt_q;
    rword_d = rword_q;  rused_d = rused_q;  rpos_d = rpos_q;
    rsel_d = rsel_q;  tsel_d = tsel_q;  bit_d = bit_q;
    cur_d = cur_q;  next_d = next_q;  sroot_d = sroot_q;  droot_d = droot_q;
    len_d = len_q;  sp_d = sp_q;  bcnt_d = bcnt_q;
    size_d = size_q;  rem_d = rem_q;  prod_d = prod_q;  cleft_d = cleft_q;
    cdist_d = cdist_q;  fadr_d = fadr_q;  w0_d = w0_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ores_d = ores_q;
    cm_we = 1'b0;  cm_re = 1'b0;  cm_waddr = wcnt_q[AW-1:0];  cm_raddr = fadr_q;
    node_we_l = 1'b0;  node_we_r = 1'b0;  node_re = 1'b0;
    node_addr = ndiff[MaxBits-1:0];
    stk_we = 1'b0;  stk_re = 1'b0;  stk_waddr = sp_q;  stk_raddr = sp_q - NW'(1);
    stk_wdata = {1'b1, next_q};
    win_we = 1'b0;  win_re = 1'b0;  win_waddr = prod_q[DB-1:0];
    win_raddr = prod_q[DB-1:0] - cdist_q - DB'(1);
    win_wdata = 8'd0;
    consume = 1'b0;  nxt = st_q;
    do_emit = 1'b0;  emit_byte = 8'd0;  do_fail = 1'b0;  fail_code = ERR_OK;
    bdone = 1'b0;

    case (st_q)
      S_WAIT: begin
        if (in_acc) begin
          case (in_i.data.func)
            FUNC_LOAD: begin
              if (wcnt_q < CW'(COMPRESSED_WORDS)) begin
                cm_we  = 1'b1;
                wcnt_d = wcnt_q + CW'(1);
              end
            end
            FUNC_CLEAR: begin
              wcnt_d = '0;
              rword_d[0] = '0;  rword_d[1] = '0;
              rused_d[0] = '0;  rused_d[1] = '0;
              rpos_d[0] = '0;   rpos_d[1] = '0;
              rem_d = '0;  prod_d = '0;  cleft_d = '0;  cdist_d = '0;
              phase_d = PH_IDLE;  err_d = ERR_OK;
              sroot_d = '0;  droot_d = '0;
            end
            FUNC_REQ: begin
              case (phase_q)
                PH_IDLE: begin
                  if (wcnt_q < CW'(HDR_WORDS)) begin
                    do_fail = 1'b1;  fail_code = ERR_OVERRUN;
                  end else begin
                    cm_re = 1'b1;  cm_raddr = AW'(SIZE_WORD);
                    st_d = S_H2;
                  end
                end
                PH_RUN: st_d = S_DEC;
                PH_FAIL: begin
                  do_fail = 1'b1;  fail_code = err_q;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      S_H2: begin
        size_d = cm_rdata_q[23:0];
        if (cm_rdata_q[23:0] == 24'd0) begin
          phase_d = PH_DONE;
          st_d = S_WAIT;
        end else begin
          if ({1'b0, sym_bits_q} < SYM_BITS_MIN) jsb_d = SYM_BITS_MIN;
          else if ({1'b0, sym_bits_q} > 5'(SB)) jsb_d = 5'(SB);
          else jsb_d = {1'b0, sym_bits_q};
          if ({1'b0, dist_bits_q} < DIST_BITS_MIN) jdb_d = DIST_BITS_MIN;
          else if ({1'b0, dist_bits_q} > 5'(DB)) jdb_d = 5'(DB);
          else jdb_d = {1'b0, dist_bits_q};
          cm_re = 1'b1;  cm_raddr = AW'(DIST_OFS_WORD);
          st_d = S_H3;
        end
      end
      S_H3: begin
        rpos_d[1] = PW'(cm_rdata_q);
        rsel_d = 1'b1;
        ret_d = S_H4;
        st_d = S_F0;
      end
      S_H4: begin
        rpos_d[0] = PW'(SYM_START);
        rsel_d = 1'b0;  tsel_d = 1'b0;
        next_d = NW'(1) << jsb_q;
        sp_d = '0;
        ret_d = S_BBIT;
        st_d = S_F0;
      end
      S_F0: begin
        if (({1'b0, rp} + (PW+1)'(4)) > (PW+1)'({wcnt_q, 2'b00})) begin
          do_fail = 1'b1;  fail_code = ERR_OVERRUN;
        end else begin
          cm_re = 1'b1;  cm_raddr = rp[AW+1:2];
          fadr_d = rp[AW+1:2];
          st_d = S_F1;
        end
      end
      S_F1: begin
        w0_d = cm_rdata_q;
        if (rp[1:0] != 2'd0) begin
          cm_re = 1'b1;  cm_raddr = fadr_q + AW'(1);
        end
        st_d = S_F2;
      end
      S_F2: begin
        rword_d[rsel_q] = fsh[63:32];
        rused_d[rsel_q] = 5'd0;
        rpos_d[rsel_q]  = rp + PW'(4);
        st_d = ret_q;
      end
      S_BBIT: begin
        consume = 1'b1;  bit_d = rbit;  nxt = S_BACT;
      end
      S_BACT: begin
        if (bit_q) begin
          if (next_q > lim2) begin
            do_fail = 1'b1;  fail_code = ERR_TREE;
          end else begin
            stk_we = 1'b1;
            st_d = S_BPUSHL;
          end
        end else begin
          bcnt_d = tsel_q ? jdb_q : jsb_q;
          cur_d = '0;
          st_d = S_BLEAF;
        end
      end
      S_BPUSHL: begin
        stk_we = 1'b1;  stk_waddr = sp_q + NW'(1);  stk_wdata = {1'b0, next_q};
        sp_d = sp_q + NW'(2);
        next_d = next_q + NW'(1);
        st_d = S_BBIT;
      end
      S_BLEAF: begin
        consume = 1'b1;
        cur_d = {cur_q[NW-2:0], rbit};
        bcnt_d = bcnt_q - 5'd1;
        nxt = (bcnt_q == 5'd1) ? S_BPOP : S_BLEAF;
      end
      S_BPOP: begin
        if (sp_q == '0) begin
          bdone = 1'b1;
        end else begin
          stk_re = 1'b1;
          sp_d = sp_q - NW'(1);
          st_d = S_BPOPD;
        end
      end
      S_BPOPD: begin
        if (stk_rdata_q[NW]) begin
          node_we_r = 1'b1;
          cur_d = stk_rdata_q[NW-1:0];
          st_d = S_BPOP;
        end else begin
          node_we_l = 1'b1;
          if (sp_q == '0) bdone = 1'b1;
          else st_d = S_BBIT;
        end
      end
      S_DEC: begin
        if (cleft_q != 24'd0) begin
          win_re = 1'b1;
          st_d = S_CPY;
        end else begin
          cur_d = sroot_q;  tsel_d = 1'b0;  rsel_d = 1'b0;
          st_d = S_WALK;
        end
      end
      S_WALK: begin
        if (cur_q >= lim) begin
          consume = 1'b1;  bit_d = rbit;  node_re = 1'b1;  nxt = S_WRD;
        end else if (!tsel_q) begin
          if (cur_q < NW'(LEN_BASE)) begin
            do_emit = 1'b1;  emit_byte = cur_q[7:0];
          end else begin
            len_d = cur_q - NW'(LEN_BASE) + NW'(LEN_ADD);
            cur_d = droot_q;  tsel_d = 1'b1;  rsel_d = 1'b1;
          end
        end else if (24'(len_q) > rem_q) begin
          do_fail = 1'b1;  fail_code = ERR_LENGTH;
        end else if (prod_q < (24'(cur_q) + 24'd1)) begin
          do_fail = 1'b1;  fail_code = ERR_DISTANCE;
        end else begin
          cleft_d = 24'(len_q);
          cdist_d = cur_q[DB-1:0];
          win_re = 1'b1;
          win_raddr = prod_q[DB-1:0] - cur_q[DB-1:0] - DB'(1);
          st_d = S_CPY;
        end
      end
      S_WRD: begin
        cur_d = bit_q ? nr : nl;
        st_d = S_WALK;
      end
      S_CPY: begin
        cleft_d = cleft_q - 24'd1;
        do_emit = 1'b1;  emit_byte = win_rdata_q;
      end
      default: st_d = S_WAIT;
    endcase

    // bit consumed from the active reader, refill when its word runs out
    if (consume) begin
      ret_d = nxt;
      if (rlast) begin
        st_d = S_F0;
      end else begin
        st_d = nxt;
        rword_d[rsel_q] = rword_q[rsel_q] << 1;
        rused_d[rsel_q] = rused_q[rsel_q] + 5'd1;
      end
    end

    if (bdone) begin
      if (!tsel_q) begin
        sroot_d = cur_q;
        tsel_d = 1'b1;  rsel_d = 1'b1;
        next_d = NW'(1) << jdb_q;
        sp_d = '0;
        st_d = S_BBIT;
      end else begin
        droot_d = cur_q;
        rem_d = size_q;  prod_d = '0;  cleft_d = '0;
        phase_d = PH_RUN;
        st_d = S_DEC;
      end
    end

    if (do_emit) begin
      win_we = 1'b1;  win_wdata = emit_byte;
      prod_d = prod_q + 24'd1;
      rem_d = rem_q - 24'd1;
      ovalid_d = 1'b1;
      ores_d.out_byte = emit_byte;
      ores_d.last = rem_q == 24'd1;
      ores_d.error = ERR_OK;
      if (rem_q == 24'd1) phase_d = PH_DONE;
      st_d = S_WAIT;
    end

    if (do_fail) begin
      phase_d = PH_FAIL;
      err_d = fail_code;
      ovalid_d = 1'b1;
      ores_d.out_byte = 8'd0;
      ores_d.last = 1'b1;
      ores_d.error = fail_code;
      st_d = S_WAIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_WAIT;  ret_q <= S_WAIT;
      phase_q <= PH_IDLE;  err_q <= ERR_OK;
      sym_bits_q <= SYM_BITS_RST;  dist_bits_q <= DIST_BITS_RST;
      jsb_q <= {1'b0, SYM_BITS_RST};  jdb_q <= {1'b0, DIST_BITS_RST};
      wcnt_q <= '0;
      rword_q[0] <= '0;  rword_q[1] <= '0;
      rused_q[0] <= '0;  rused_q[1] <= '0;
      rpos_q[0] <= '0;   rpos_q[1] <= '0;
      rsel_q <= 1'b0;  tsel_q <= 1'b0;  bit_q <= 1'b0;
      cur_q <= '0;  next_q <= '0;  sroot_q <= '0;  droot_q <= '0;
      len_q <= '0;  sp_q <= '0;  bcnt_q <= '0;
      size_q <= '0;  rem_q <= '0;  prod_q <= '0;  cleft_q <= '0;
      cdist_q <= '0;  fadr_q <= '0;  w0_q <= '0;
      ovalid_q <= 1'b0;  ores_q <= '0;
    end else begin
      st_q <= st_d;  ret_q <= ret_d;
      phase_q <= phase_d;  err_q <= err_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.data.index)
          CFG_SYM_BITS:  sym_bits_q <= cfg_i.data.value;
          CFG_DIST_BITS: dist_bits_q <= cfg_i.data.value;
          default: ;
        endcase
      end
      jsb_q <= jsb_d;  jdb_q <= jdb_d;
      wcnt_q <= wcnt_d;
      rword_q <= rword_d;  rused_q <= rused_d;  rpos_q <= rpos_d;
      rsel_q <= rsel_d;  tsel_q <= tsel_d;  bit_q <= bit_d;
      cur_q <= cur_d;  next_q <= next_d;  sroot_q <= sroot_d;  droot_q <= droot_d;
      len_q <= len_d;  sp_q <= sp_d;  bcnt_q <= bcnt_d;
      size_q <= size_d;  rem_q <= rem_d;  prod_q <= prod_d;  cleft_q <= cleft_d;
      cdist_q <= cdist_d;  fadr_q <= fadr_d;  w0_q <= w0_d;
      ovalid_q <= ovalid_d;  ores_q <= ores_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cm_we) cmem[cm_waddr] <= in_i.data.data_word;
    if (cm_re) cm_rdata_q <= cmem[cm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (node_we_l && !tsel_q) sym_l[node_addr[SB-1:0]] <= cur_q[SB:0];
    if (node_we_r && !tsel_q) sym_r[node_addr[SB-1:0]] <= cur_q[SB:0];
    if (node_re && !tsel_q) begin
      sl_rdata_q <= sym_l[node_addr[SB-1:0]];
      sr_rdata_q <= sym_r[node_addr[SB-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_we_l && tsel_q) dst_l[node_addr[DB-1:0]] <= cur_q[DB:0];
    if (node_we_r && tsel_q) dst_r[node_addr[DB-1:0]] <= cur_q[DB:0];
    if (node_re && tsel_q) begin
      dl_rdata_q <= dst_l[node_addr[DB-1:0]];
      dr_rdata_q <= dst_r[node_addr[DB-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata_q <= stk[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (win_we) win[win_waddr] <= win_wdata;
    if (win_re) win_rdata_q <= win[win_raddr];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_FAIL |-> err_q != ERR_OK)
    else $error("failed job without error code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) && ores_q.error != ERR_OK |-> ores_q.last)
    else $error("error word not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_RUN |-> rem_q != 24'd0)
    else $error("running job with nothing left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cleft_q != 24'd0 |-> phase_q == PH_RUN)
    else $error("pending copy outside a running job");

endmodule

// ===== sim/lz_huffman_tree_decompressor_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_huffman_tree_decompressor_top_tb
// Self-checking testbench: builds compressed jobs with balanced huffman trees,
// streams them in with random gaps and stalls, and checks every output byte
// against a cycle-free predictor of the decompressor.
// ----------------------------------------------------------------------------
module lz_huffman_tree_decompressor_top_tb;
  import lzh_pkg::*;

  localparam int          CW         = 16384;
  localparam int          MAX_SYM    = 12;
  localparam int          MAX_DIST   = 15;
  localparam int unsigned SYM_NODES  = (2 << MAX_SYM) - 1;
  localparam int unsigned DIST_NODES = (2 << MAX_DIST) - 1;
  localparam int unsigned STACK_MAX  = 2 << MAX_DIST;
  localparam int unsigned WIN        = 1 << MAX_DIST;
  localparam int unsigned SIZE_MASK  = 32'h00FF_FFFF;
  localparam int unsigned TAG_R      = 32'h8000_0000;
  localparam int unsigned TAG_L      = 32'h4000_0000;
  localparam int unsigned NODE_MASK  = 32'h3FFF_FFFF;
  localparam int          WATCHDOG   = 20000;
  localparam int          SETTLE     = 200;

  typedef struct {
    logic [31:0]     word;
    int unsigned     used;
    longint unsigned pos;
  } reader_t;

  logic clk_i;
  logic rst_ni;

  lzh_in_if  in_if ();
  lzh_out_if out_if ();
  lzh_cfg_if cfg_if ();

  lz_huffman_tree_decompressor_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state
  logic [3:0]  sym_bits_reg;
  logic [3:0]  dist_bits_reg;
  logic [31:0] cmem [CW];
  int unsigned nwords;
  int unsigned left_child [2][DIST_NODES];
  int unsigned right_child [2][DIST_NODES];
  int unsigned build_stack [STACK_MAX];
  logic [7:0]  window [WIN];
  reader_t     rdr [2];
  int unsigned remaining, produced, copy_left, copy_dist;
  logic [1:0]  phase;
  logic [2:0]  err_code;
  int unsigned job_sym_bits, job_dist_bits, tree_root [2];

  in_word_t  pending_words [$];
  out_word_t expected_bytes [$];

  int  fails, bytes_checked, errors_seen, items_sent, jobs_run, idle_cycles;
  int  in_gap, out_stall, draw_s;
  bit  no_idle;

  // job builder state
  logic        sym_stream [$];
  logic        dist_stream [$];
  logic [7:0]  job_bytes [$];
  int unsigned sym_leaf [16];
  int unsigned dist_leaf [16];
  int          leaf_ctr [2];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    fails++;
    if (fails <= 40) $display("MISMATCH: %s", msg);
  endtask

  function automatic int unsigned clamp_sym(logic [3:0] v);
    return v < 9 ? 9 : (v > MAX_SYM ? MAX_SYM : v);
  endfunction

  function automatic int unsigned clamp_dist(logic [3:0] v);
    return v < 1 ? 1 : (v > MAX_DIST ? MAX_DIST : v);
  endfunction

  function automatic logic [7:0] mem_byte(longint unsigned a);
    logic [31:0] w;
    w = cmem[(a >> 2) % CW];
    return w >> (24 - 8 * (a & 3));
  endfunction

  function automatic bit refill(int k);
    longint unsigned p;
    p = rdr[k].pos;
    if (p + 4 > longint'(nwords) * 4) return 1'b0;
    rdr[k].word = {mem_byte(p), mem_byte(p + 1), mem_byte(p + 2), mem_byte(p + 3)};
    rdr[k].used = 0;
    rdr[k].pos  = p + 4;
    return 1'b1;
  endfunction

  function automatic bit next_bit(int k, output logic b);
    b = rdr[k].word[31];
    if (rdr[k].used == 31) return refill(k);
    rdr[k].used++;
    rdr[k].word = rdr[k].word << 1;
    return 1'b1;
  endfunction

  function automatic int build_tree(int k, int unsigned width);
    int unsigned lim, nxt, n, cur, e, idx;
    logic b;
    lim = 1 << width;
    nxt = lim;
    n   = 0;
    while (1) begin
      if (!next_bit(k, b)) return ERR_OVERRUN;
      if (b) begin
        if (nxt > 2 * lim - 2 || n + 2 > STACK_MAX) return ERR_TREE;
        build_stack[n] = nxt | TAG_R;
        build_stack[n + 1] = nxt | TAG_L;
        n += 2;
        nxt++;
      end else begin
        cur = 0;
        for (int i = 0; i < width; i++) begin
          if (!next_bit(k, b)) return ERR_OVERRUN;
          cur = (cur << 1) | b;
        end
        while (n > 0) begin
          n--;
          e   = build_stack[n];
          idx = e & NODE_MASK;
          if (e & TAG_R) begin
            right_child[k][idx] = cur;
            cur = idx;
          end else begin
            left_child[k][idx] = cur;
            break;
          end
        end
        if (n == 0) begin
          tree_root[k] = cur;
          return ERR_OK;
        end
      end
    end
  endfunction

  function automatic bit walk_tree(int k, int unsigned lim, output int unsigned leaf);
    int unsigned cur;
    logic b;
    cur = tree_root[k];
    while (cur >= lim) begin
      if (!next_bit(k, b)) return 1'b0;
      cur = b ? right_child[k][cur] : left_child[k][cur];
    end
    leaf = cur;
    return 1'b1;
  endfunction

  function automatic void push_byte(logic [7:0] b, logic l, logic [2:0] e);
    out_word_t w;
    w.out_byte = b;
    w.last     = l;
    w.error    = e;
    expected_bytes.push_back(w);
  endfunction

  function automatic void fail_job(logic [2:0] code);
    err_code = code;
    phase    = PH_FAIL;
    push_byte(8'd0, 1'b1, code);
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    window[produced & (WIN - 1)] = b;
    produced = (produced + 1) & SIZE_MASK;
    remaining--;
    push_byte(b, remaining == 0, ERR_OK);
    if (remaining == 0) phase = PH_DONE;
  endfunction

  function automatic void copy_byte();
    copy_left--;
    emit_byte(window[(produced - copy_dist - 1) & (WIN - 1)]);
  endfunction

  function automatic void decode_byte();
    int unsigned sym, dleaf, len;
    if (copy_left > 0) begin
      copy_byte();
      return;
    end
    if (!walk_tree(0, 1 << job_sym_bits, sym)) begin
      fail_job(ERR_OVERRUN);
      return;
    end
    if (sym < LEN_BASE) begin
      emit_byte(sym[7:0]);
      return;
    end
    if (!walk_tree(1, 1 << job_dist_bits, dleaf)) begin
      fail_job(ERR_OVERRUN);
      return;
    end
    len = sym - LEN_BASE + LEN_ADD;
    if (len > remaining) begin
      fail_job(ERR_LENGTH);
      return;
    end
    if (produced < dleaf + 1) begin
      fail_job(ERR_DISTANCE);
      return;
    end
    copy_left = len;
    copy_dist = dleaf;
    copy_byte();
  endfunction

  function automatic void start_job();
    int unsigned size, e;
    if (nwords < HDR_WORDS) begin
      fail_job(ERR_OVERRUN);
      return;
    end
    size = cmem[SIZE_WORD] & SIZE_MASK;
    if (size == 0) begin
      phase = PH_DONE;
      return;
    end
    job_sym_bits  = clamp_sym(sym_bits_reg);
    job_dist_bits = clamp_dist(dist_bits_reg);
    for (int i = 0; i < DIST_NODES; i++) begin
      left_child[0][i]  = 0;
      right_child[0][i] = 0;
      left_child[1][i]  = 0;
      right_child[1][i] = 0;
    end
    rdr[1].pos = cmem[DIST_OFS_WORD];
    if (!refill(1)) begin
      fail_job(ERR_OVERRUN);
      return;
    end
    rdr[0].pos = SYM_START;
    if (!refill(0)) begin
      fail_job(ERR_OVERRUN);
      return;
    end
    e = build_tree(0, job_sym_bits);
    if (e != ERR_OK) begin
      fail_job(3'(e));
      return;
    end
    e = build_tree(1, job_dist_bits);
    if (e != ERR_OK) begin
      fail_job(3'(e));
      return;
    end
    remaining = size;
    produced  = 0;
    copy_left = 0;
    copy_dist = 0;
    phase     = PH_RUN;
    decode_byte();
  endfunction

  function automatic void clear_job();
    nwords = 0;
    for (int k = 0; k < 2; k++) begin
      rdr[k].word = 0;
      rdr[k].used = 0;
      rdr[k].pos  = 0;
      tree_root[k] = 0;
    end
    remaining = 0;
    produced  = 0;
    copy_left = 0;
    copy_dist = 0;
    phase     = PH_IDLE;
    err_code  = ERR_OK;
  endfunction

  function automatic void predict_output_byte(in_word_t w);
    case (w.func)
      FUNC_LOAD: begin
        if (nwords < CW) begin
          cmem[nwords] = w.data_word;
          nwords++;
        end
      end
      FUNC_CLEAR: clear_job();
      FUNC_REQ: begin
        case (phase)
          PH_IDLE: start_job();
          PH_RUN:  decode_byte();
          PH_FAIL: fail_job(err_code);
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      in_gap      <= 0;
    end else begin
      if (in_if.valid && in_if.ready) predict_output_byte(in_if.data);
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap      <= in_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_if.data  <= pending_words.pop_front();
          in_if.valid <= 1'b1;
          in_gap      <= no_idle ? 0 : $urandom_range(0, 9);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected word byte=%0h last=%0b err=%0d",
                                    out_if.data.out_byte, out_if.data.last,
                                    out_if.data.error));
        end else begin
          if (out_if.data.out_byte !== expected_bytes[0].out_byte)
            report_mismatch($sformatf("out_byte %0h, expected %0h", out_if.data.out_byte,
                                      expected_bytes[0].out_byte));
          if (out_if.data.last !== expected_bytes[0].last)
            report_mismatch($sformatf("last %0b, expected %0b", out_if.data.last,
                                      expected_bytes[0].last));
          if (out_if.data.error !== expected_bytes[0].error)
            report_mismatch($sformatf("error %0d, expected %0d", out_if.data.error,
                                      expected_bytes[0].error));
          if (expected_bytes[0].error != ERR_OK) errors_seen++;
          void'(expected_bytes.pop_front());
          bytes_checked++;
        end
        draw_s = no_idle ? 0 : $urandom_range(0, 9);
        out_stall    <= draw_s;
        out_if.ready <= (draw_s == 0);
      end else if (out_stall > 0) begin
        out_stall    <= out_stall - 1;
        out_if.ready <= (out_stall == 1);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_word(logic [1:0] f, logic [31:0] d);
    in_word_t w;
    w.func      = f;
    w.data_word = d;
    pending_words.push_back(w);
    items_sent++;
  endtask

  task automatic settle();
    while (pending_words.size() != 0 || in_if.valid || expected_bytes.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [3:0] v);
    @(posedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.value <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_SYM_BITS) sym_bits_reg = v;
    else dist_bits_reg = v;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic push_bits(int which, int unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) begin
      if (which == 0) sym_stream.push_back(v[i]);
      else dist_stream.push_back(v[i]);
    end
  endtask

  // preorder: internal node, left subtree, right subtree
  task automatic emit_tree(int which, int level, int depth, int width);
    if (level == depth) begin
      push_bits(which, 0, 1);
      push_bits(which, which == 0 ? sym_leaf[leaf_ctr[0]] : dist_leaf[leaf_ctr[1]], width);
      leaf_ctr[which]++;
    end else begin
      push_bits(which, 1, 1);
      emit_tree(which, level + 1, depth, width);
      emit_tree(which, level + 1, depth, width);
    end
  endtask

  task automatic pack_stream(int which);
    int unsigned n;
    logic [7:0]  bv;
    n = which == 0 ? sym_stream.size() : dist_stream.size();
    for (int i = 0; i < (n + 7) / 8; i++) begin
      bv = 8'h00;
      for (int j = 0; j < 8; j++)
        if (i * 8 + j < n) bv[7 - j] = which == 0 ? sym_stream[i * 8 + j] : dist_stream[i * 8 + j];
      job_bytes.push_back(bv);
    end
  endtask

  task automatic run_job(int sd, int dd, int size, bit broken, int extra_req);
    int unsigned sw, dw, dmax, made, rem, len, i, j, ofs, nw;
    bit          took;
    sw   = clamp_sym(sym_bits_reg);
    dw   = clamp_dist(dist_bits_reg);
    dmax = ((1 << dw) - 1) < 7 ? (1 << dw) - 1 : 7;
    for (int k = 0; k < 16; k++) begin
      if (k == 0 || $urandom_range(0, 1)) sym_leaf[k] = $urandom_range(0, 255);
      else if ($urandom_range(0, 3) == 0) sym_leaf[k] = $urandom_range(0, (1 << sw) - 1);
      else sym_leaf[k] = LEN_BASE + $urandom_range(0, 5);
      dist_leaf[k] = $urandom_range(0, 4) == 0 ? $urandom_range(0, (1 << dw) - 1)
                                               : $urandom_range(0, dmax);
    end
    sym_stream.delete();
    dist_stream.delete();
    job_bytes.delete();
    leaf_ctr[0] = 0;
    leaf_ctr[1] = 0;
    emit_tree(0, 0, sd, sw);
    emit_tree(1, 0, dd, dw);
    made = 0;
    rem  = size;
    while (rem > 0) begin
      took = 1'b0;
      for (int t = 0; t < 4 && !took; t++) begin
        i = $urandom_range(0, (1 << sd) - 1);
        if (sym_leaf[i] < LEN_BASE) begin
          push_bits(0, i, sd);
          made++;
          rem--;
          took = 1'b1;
        end else begin
          len = sym_leaf[i] - LEN_BASE + LEN_ADD;
          j   = $urandom_range(0, (1 << dd) - 1);
          if (broken || (len <= rem && dist_leaf[j] + 1 <= made)) begin
            push_bits(0, i, sd);
            push_bits(1, j, dd);
            made += len;
            rem = len > rem ? 0 : rem - len;
            took = 1'b1;
          end
        end
      end
      if (!took) begin
        push_bits(0, 0, sd);
        made++;
        rem--;
      end
    end
    for (int k = 0; k < 4; k++) job_bytes.push_back($urandom_range(0, 255));
    job_bytes.push_back($urandom_range(0, 255));
    job_bytes.push_back(size[23:16]);
    job_bytes.push_back(size[15:8]);
    job_bytes.push_back(size[7:0]);
    for (int k = 0; k < 4; k++) job_bytes.push_back(8'h00);
    pack_stream(0);
    while (job_bytes.size() % 4 != 0) job_bytes.push_back($urandom_range(0, 255));
    for (int k = 0; k < 8; k++) job_bytes.push_back($urandom_range(0, 255));
    repeat ($urandom_range(0, 3)) job_bytes.push_back($urandom_range(0, 255));
    ofs = job_bytes.size();
    pack_stream(1);
    for (int k = 0; k < 8; k++) job_bytes.push_back($urandom_range(0, 255));
    while (job_bytes.size() % 4 != 0) job_bytes.push_back($urandom_range(0, 255));
    if (broken) begin
      case ($urandom_range(0, 3))
        0: begin
          i = $urandom_range(12, job_bytes.size() - 1);
          job_bytes[i] = job_bytes[i] ^ (8'h01 << $urandom_range(0, 7));
        end
        1: repeat (4 * $urandom_range(1, 3)) void'(job_bytes.pop_back());
        2: ofs = $urandom;
        default: ;
      endcase
    end
    job_bytes[8]  = ofs[31:24];
    job_bytes[9]  = ofs[23:16];
    job_bytes[10] = ofs[15:8];
    job_bytes[11] = ofs[7:0];
    nw = job_bytes.size() / 4;
    for (int k = 0; k < nw; k++)
      queue_word(FUNC_LOAD, {job_bytes[4 * k], job_bytes[4 * k + 1], job_bytes[4 * k + 2],
                             job_bytes[4 * k + 3]});
    for (int k = 0; k < size + extra_req; k++) begin
      if (broken && $urandom_range(0, 9) == 0)
        queue_word($urandom_range(0, 1) ? FUNC_NOP : FUNC_LOAD, $urandom);
      queue_word(FUNC_REQ, $urandom);
    end
    queue_word(FUNC_CLEAR, $urandom);
    jobs_run++;
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    sym_bits_reg  = SYM_BITS_RST;
    dist_bits_reg = DIST_BITS_RST;
    for (int k = 0; k < CW; k++) cmem[k] = '0;
    clear_job();
    fails = 0;
    bytes_checked = 0;
    errors_seen = 0;
    items_sent = 0;
    jobs_run = 0;
    no_idle = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short header, sticky error, unused selector
    queue_word(FUNC_REQ, 32'hFFFF_FFFF);
    queue_word(FUNC_REQ, 32'h0000_0000);
    queue_word(FUNC_NOP, 32'hA5A5_A5A5);
    queue_word(FUNC_CLEAR, 32'h0);
    // zero output size, then requests after the end
    queue_word(FUNC_LOAD, 32'h0);
    queue_word(FUNC_LOAD, 32'hFF00_0000);
    queue_word(FUNC_LOAD, 32'h0000_000C);
    queue_word(FUNC_REQ, 32'h0);
    queue_word(FUNC_REQ, 32'h0);
    queue_word(FUNC_CLEAR, 32'h0);
    settle();
    // clamped widths at the low end, distance tree overflow
    write_reg(CFG_SYM_BITS, 4'd0);
    write_reg(CFG_DIST_BITS, 4'd0);
    run_job(1, 2, 4, 1'b0, 1);
    settle();
    // symbol width clamped at the high end, distance width at its maximum, single leaf trees
    write_reg(CFG_SYM_BITS, 4'd15);
    write_reg(CFG_DIST_BITS, 4'd15);
    run_job(0, 0, 5, 1'b0, 2);
    settle();
    write_reg(CFG_SYM_BITS, 4'd9);
    write_reg(CFG_DIST_BITS, 4'd1);
    run_job(2, 1, 12, 1'b0, 1);

    while (items_sent < 850) begin
      settle();
      no_idle = ($urandom_range(0, 3) == 0);
      if (jobs_run % 3 == 0) begin
        write_reg(CFG_SYM_BITS, $urandom_range(0, 3) == 0 ? 4'd12 : $urandom_range(0, 15));
        write_reg(CFG_DIST_BITS, $urandom_range(0, 3) == 0 ? 4'd15 : $urandom_range(0, 15));
      end
      run_job($urandom_range(0, 4), $urandom_range(0, 3),
              $urandom_range(0, 9) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 24),
              $urandom_range(0, 4) == 0, $urandom_range(0, 3));
    end

    settle();
    if (expected_bytes.size() != 0) report_mismatch("expectations left over at end");
    $display("covered %0d jobs, %0d input words, %0d output words checked (%0d with error)",
             jobs_run, items_sent, bytes_checked, errors_seen);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== lz_huffman_tree_decompressor_top.f =====
src/lzh_pkg.sv
src/lzh_if.sv
src/lz_huffman_tree_decompressor_top.sv
sim/lz_huffman_tree_decompressor_top_tb.sv
